// File: rtl/ifl_pkg.sv
// ----------------------------------------------------------------------------
// ifl_pkg: shared definitions of the forwarding lookup
// Table sizes, status codes, opcodes and the control bundle between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package ifl_pkg;

	localparam int LOCAL_ENTRIES = 16;
	localparam int ROUTE_ENTRIES = 32;
	localparam int ARP_ENTRIES   = 32;

	localparam int LOCAL_IW = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
	localparam int ROUTE_IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int ARP_IW   = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;

	localparam int SLOT_W = 5;

	// Opcodes carried in the request's tuser.
	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_LOCAL = 2'd1;
	localparam logic [1:0] OP_ROUTE = 2'd2;
	localparam logic [1:0] OP_ARP   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_FORWARD   = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_NOT_LOCAL = 3'd2;
	localparam logic [2:0] ST_NOT_IPV4  = 3'd3;
	localparam logic [2:0] ST_NO_ROUTE  = 3'd4;
	localparam logic [2:0] ST_NO_ARP    = 3'd5;
	localparam logic [2:0] ST_NO_PORT   = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PORT1   = 2'd0;
	localparam logic [1:0] CFG_PORT2_A = 2'd1;
	localparam logic [1:0] CFG_PORT2_B = 2'd2;

	localparam logic [23:0] PORT1_RESET   = 24'hC0A800;
	localparam logic [23:0] PORT2_A_RESET = 24'hC0A801;
	localparam logic [23:0] PORT2_B_RESET = 24'hC0A802;

	localparam logic [11:0] MIN_FRAME_BYTES = 12'd42;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;

	localparam logic [1:0] PORT_NONE = 2'd0;
	localparam logic [1:0] PORT_ONE  = 2'd1;
	localparam logic [1:0] PORT_TWO  = 2'd2;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;      // capture an accepted request
		logic match;     // compare local and route tables
		logic route;     // pick route slot, fetch gateway
		logic arp;       // compare ARP table against gateway
		logic result;    // form result into output register
	} ifl_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic is_frame;  // incoming request is a frame header
	} ifl_stat_t;

endpackage

// File: rtl/ifl_ctrl.sv
// ----------------------------------------------------------------------------
// ifl_ctrl: lookup sequencer
// Steps a frame header through the match, route, ARP and result phases
// and owns the handshakes of both streams.
// ----------------------------------------------------------------------------
module ifl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  ifl_pkg::ifl_stat_t stat,
	output ifl_pkg::ifl_cmd_t  cmd
);
	import ifl_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MATCH  = 3'd1;
	localparam logic [2:0] S_ROUTE  = 3'd2;
	localparam logic [2:0] S_ARP    = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	// The output register is free when empty or being drained.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Commands follow the current phase.
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.match  = (state_q == S_MATCH);
		cmd.route  = (state_q == S_ROUTE);
		cmd.arp    = (state_q == S_ARP);
		cmd.result = (state_q == S_RESULT) && out_free;
	end

	// Next phase.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && stat.is_frame) state_d = S_MATCH;
			end
			S_MATCH:  state_d = S_ROUTE;
			S_ROUTE:  state_d = S_ARP;
			S_ARP:    state_d = S_RESULT;
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Phase and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/ifl_datapath.sv
// ----------------------------------------------------------------------------
// ifl_datapath: tables, compares and result register
// Holds the local MAC, route and ARP tables with their valid bits, the
// subnet registers, the captured request and the output payload.
// ----------------------------------------------------------------------------
module ifl_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         opcode,
	input  logic [4:0]         entry_index,
	input  logic [47:0]        hw_addr,
	input  logic [15:0]        ether_type,
	input  logic [31:0]        ip_addr,
	input  logic [31:0]        gateway_ip,
	input  logic [11:0]        frame_length,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  ifl_pkg::ifl_cmd_t  cmd,
	output ifl_pkg::ifl_stat_t stat,
	output logic [2:0]         status,
	output logic [1:0]         egress_port,
	output logic [47:0]        new_dst_mac,
	output logic [47:0]        new_src_mac,
	output logic [4:0]         route_slot,
	output logic [4:0]         arp_slot
);
	import ifl_pkg::*;

	// Tables and valid bits.
	logic [47:0] local_mac_q [LOCAL_ENTRIES];
	logic [LOCAL_ENTRIES-1:0] local_valid_q;
	logic [31:0] route_dest_q [ROUTE_ENTRIES];
	logic [31:0] route_gw_q [ROUTE_ENTRIES];
	logic [ROUTE_ENTRIES-1:0] route_valid_q;
	logic [31:0] arp_ip_q [ARP_ENTRIES];
	logic [47:0] arp_mac_q [ARP_ENTRIES];
	logic [ARP_ENTRIES-1:0] arp_valid_q;

	logic [23:0] port1_q;
	logic [23:0] port2a_q;
	logic [23:0] port2b_q;

	// Captured frame header.
	logic [47:0] mac_q;
	logic [15:0] etype_q;
	logic [31:0] ip_q;
	logic [11:0] len_q;

	// Lookup intermediates.
	logic                     local_hit_q;
	logic [ROUTE_ENTRIES-1:0] route_hits_q;
	logic                     route_found_q;
	logic [ROUTE_IW-1:0]      rslot_q;
	logic [31:0]              gw_q;
	logic [ARP_ENTRIES-1:0]   arp_hits_q;

	logic [LOCAL_ENTRIES-1:0] local_hits;
	logic [ROUTE_ENTRIES-1:0] route_hits;
	logic [ARP_ENTRIES-1:0]   arp_hits;
	logic [ROUTE_IW-1:0]      rslot;
	logic [ARP_IW-1:0]        aslot;
	logic [23:0]              net;
	logic [1:0]               port;
	logic                     wr;

	assign stat.is_frame = (opcode == OP_FRAME);
	assign wr = cmd.load;

	// Table writes at request accept.
	always_ff @(posedge clk) begin
		if (wr && opcode == OP_LOCAL && {1'b0, entry_index} < 6'(LOCAL_ENTRIES))
			local_mac_q[entry_index[LOCAL_IW-1:0]] <= hw_addr;
		if (wr && opcode == OP_ROUTE && {1'b0, entry_index} < 6'(ROUTE_ENTRIES)) begin
			route_dest_q[entry_index[ROUTE_IW-1:0]] <= ip_addr;
			route_gw_q[entry_index[ROUTE_IW-1:0]]   <= gateway_ip;
		end
		if (wr && opcode == OP_ARP && {1'b0, entry_index} < 6'(ARP_ENTRIES)) begin
			arp_ip_q[entry_index[ARP_IW-1:0]]  <= ip_addr;
			arp_mac_q[entry_index[ARP_IW-1:0]] <= hw_addr;
		end
	end

	// Valid bits and subnet registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_valid_q <= '0;
			route_valid_q <= '0;
			arp_valid_q   <= '0;
			port1_q       <= PORT1_RESET;
			port2a_q      <= PORT2_A_RESET;
			port2b_q      <= PORT2_B_RESET;
		end else begin
			if (wr && opcode == OP_LOCAL && {1'b0, entry_index} < 6'(LOCAL_ENTRIES))
				local_valid_q[entry_index[LOCAL_IW-1:0]] <= 1'b1;
			if (wr && opcode == OP_ROUTE && {1'b0, entry_index} < 6'(ROUTE_ENTRIES))
				route_valid_q[entry_index[ROUTE_IW-1:0]] <= 1'b1;
			if (wr && opcode == OP_ARP && {1'b0, entry_index} < 6'(ARP_ENTRIES))
				arp_valid_q[entry_index[ARP_IW-1:0]] <= 1'b1;
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_PORT1:   port1_q  <= cfg_data;
					CFG_PORT2_A: port2a_q <= cfg_data;
					CFG_PORT2_B: port2b_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Capture the frame header.
	always_ff @(posedge clk) begin
		if (wr) begin
			mac_q   <= hw_addr;
			etype_q <= ether_type;
			ip_q    <= ip_addr;
			len_q   <= frame_length;
		end
	end

	// Parallel compares against each entry.
	always_comb begin
		for (int k = 0; k < LOCAL_ENTRIES; k++)
			local_hits[k] = local_valid_q[k] && (local_mac_q[k] == mac_q);
		for (int k = 0; k < ROUTE_ENTRIES; k++)
			route_hits[k] = route_valid_q[k] && (route_dest_q[k] == ip_q);
		for (int k = 0; k < ARP_ENTRIES; k++)
			arp_hits[k] = arp_valid_q[k] && (arp_ip_q[k] == gw_q);
	end

	// Lowest set hit wins.
	always_comb begin
		rslot = '0;
		for (int k = ROUTE_ENTRIES - 1; k >= 0; k--)
			if (route_hits_q[k]) rslot = ROUTE_IW'(k);
		aslot = '0;
		for (int k = ARP_ENTRIES - 1; k >= 0; k--)
			if (arp_hits_q[k]) aslot = ARP_IW'(k);
	end

	// Egress port from the /24 subnet.
	always_comb begin
		net = ip_q[31:8];
		if (net == port1_q) port = PORT_ONE;
		else if (net == port2a_q || net == port2b_q) port = PORT_TWO;
		else port = PORT_NONE;
	end

	// Lookup phases.
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			local_hit_q  <= |local_hits;
			route_hits_q <= route_hits;
		end
		if (cmd.route) begin
			route_found_q <= |route_hits_q;
			rslot_q       <= rslot;
			gw_q          <= route_gw_q[rslot];
		end
		if (cmd.arp) arp_hits_q <= arp_hits;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			egress_port <= PORT_NONE;
			new_dst_mac <= '0;
			new_src_mac <= '0;
			route_slot  <= '0;
			arp_slot    <= '0;
			if (len_q < MIN_FRAME_BYTES) status <= ST_SHORT;
			else if (!local_hit_q) status <= ST_NOT_LOCAL;
			else if (etype_q != ETHERTYPE_IPV4) status <= ST_NOT_IPV4;
			else if (!route_found_q) status <= ST_NO_ROUTE;
			else begin
				route_slot <= SLOT_W'(rslot_q);
				if (!(|arp_hits_q)) status <= ST_NO_ARP;
				else begin
					arp_slot <= SLOT_W'(aslot);
					if (port == PORT_NONE) status <= ST_NO_PORT;
					else begin
						status      <= ST_FORWARD;
						egress_port <= port;
						new_dst_mac <= arp_mac_q[aslot];
						new_src_mac <= mac_q;
					end
				end
			end
		end
	end

endmodule

// File: rtl/ipv4_forwarding_lookup.sv
// ----------------------------------------------------------------------------
// ipv4_forwarding_lookup: static IPv4 forwarding lookup
// Keeps local MAC, route and ARP tables and resolves frame headers.
// ----------------------------------------------------------------------------
// A request with tuser 0 is a frame header and yields one result; tuser 1, 2
// and 3 write a local MAC, route or ARP slot and yield none. A table write is
// taken in the idle state and starts no lookup. A frame header goes from
// accept to a result in the output register through a local and route
// compare, a route pick with the gateway fetch, an ARP compare and the result
// step, each one register stage of the sequencer. A new request is taken once
// the previous header leaves the result step. All valid bits clear at reset;
// there is no clearing pass. Subnet registers are to be written through the
// cfg channel only while no header is in flight; the block does not enforce it.
module ipv4_forwarding_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: entry_index[4:0], hw_addr[52:5], ether_type[68:53],
	// ip_addr[100:69], gateway_ip[132:101], frame_length[144:133]
	input  logic [151:0] s_tdata,
	// tuser: opcode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: egress_port[1:0], new_dst_mac[49:2], new_src_mac[97:50],
	// route_slot[102:98], arp_slot[107:103]
	output logic [111:0] m_tdata,
	// tuser: status[2:0]
	output logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import ifl_pkg::*;

	ifl_cmd_t  cmd;
	ifl_stat_t stat;

	assign cfg_ready     = 1'b1;
	assign m_tdata[111:108] = '0;

	// Sequencer.
	ifl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Tables and result datapath.
	ifl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (s_tuser),
		.entry_index  (s_tdata[4:0]),
		.hw_addr      (s_tdata[52:5]),
		.ether_type   (s_tdata[68:53]),
		.ip_addr      (s_tdata[100:69]),
		.gateway_ip   (s_tdata[132:101]),
		.frame_length (s_tdata[144:133]),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.status       (m_tuser),
		.egress_port  (m_tdata[1:0]),
		.new_dst_mac  (m_tdata[49:2]),
		.new_src_mac  (m_tdata[97:50]),
		.route_slot   (m_tdata[102:98]),
		.arp_slot     (m_tdata[107:103])
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IPv4 forwarding lookup
// Fills the local MAC, route and ARP tables through table write requests,
// sends frame headers and checks every resolution against a shadow copy of
// the tables and the subnet registers. Both stream sides idle at random, and
// the subnet registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import ifl_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  port;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [4:0]  route_slot;
		logic [4:0]  arp_slot;
	} resolution_t;

	localparam int WATCHDOG_CYCLES = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [23:0]  cfg_data;

	// Shadow copy of the tables and the subnet registers.
	logic [47:0] sh_local_mac[LOCAL_ENTRIES];
	logic        sh_local_valid[LOCAL_ENTRIES];
	logic [31:0] sh_route_dest[ROUTE_ENTRIES];
	logic [31:0] sh_route_gw[ROUTE_ENTRIES];
	logic        sh_route_valid[ROUTE_ENTRIES];
	logic [31:0] sh_arp_ip[ARP_ENTRIES];
	logic [47:0] sh_arp_mac[ARP_ENTRIES];
	logic        sh_arp_valid[ARP_ENTRIES];
	logic [23:0] sh_port1;
	logic [23:0] sh_port2_a;
	logic [23:0] sh_port2_b;

	resolution_t pending_resolutions[$];
	int          mismatches;
	int          idle_cycles;
	bit          no_idle;

	// Pools of addresses so that random frames hit the tables.
	logic [47:0] mac_pool[8];
	logic [31:0] ip_pool[8];

	ipv4_forwarding_lookup i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Resolve one frame header the way the block should.
	function automatic resolution_t resolve_header(logic [47:0] mac, logic [15:0] et,
			logic [31:0] ip, logic [11:0] len);
		resolution_t res;
		bit          hit;
		int          r;
		int          a;
		logic [23:0] net;
		res = '0;
		hit = 0;
		r = -1;
		a = -1;
		net = ip[31:8];
		for (int k = 0; k < LOCAL_ENTRIES; k++)
			if (sh_local_valid[k] && sh_local_mac[k] == mac) hit = 1;
		for (int k = ROUTE_ENTRIES - 1; k >= 0; k--)
			if (sh_route_valid[k] && sh_route_dest[k] == ip) r = k;
		if (len < MIN_FRAME_BYTES) begin
			res.status = ST_SHORT;
		end else if (!hit) begin
			res.status = ST_NOT_LOCAL;
		end else if (et != ETHERTYPE_IPV4) begin
			res.status = ST_NOT_IPV4;
		end else if (r < 0) begin
			res.status = ST_NO_ROUTE;
		end else begin
			res.route_slot = r[4:0];
			for (int k = ARP_ENTRIES - 1; k >= 0; k--)
				if (sh_arp_valid[k] && sh_arp_ip[k] == sh_route_gw[r]) a = k;
			if (a < 0) begin
				res.status = ST_NO_ARP;
			end else begin
				res.arp_slot = a[4:0];
				if (net == sh_port1) res.port = PORT_ONE;
				else if (net == sh_port2_a || net == sh_port2_b) res.port = PORT_TWO;
				if (res.port == PORT_NONE) begin
					res.status = ST_NO_PORT;
				end else begin
					res.status = ST_FORWARD;
					res.dst_mac = sh_arp_mac[a];
					res.src_mac = mac;
				end
			end
		end
		return res;
	endfunction

	// Send one request and update the shadow tables once it is accepted.
	task automatic send_request(logic [1:0] op, logic [4:0] idx, logic [47:0] mac,
			logic [15:0] et, logic [31:0] ip, logic [31:0] gw, logic [11:0] len);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, len, gw, ip, et, mac, idx};
		do @(posedge clk); while (!s_tready);
		case (op)
			OP_LOCAL: begin
				if (idx < LOCAL_ENTRIES) begin
					sh_local_mac[idx] = mac;
					sh_local_valid[idx] = 1'b1;
				end
			end
			OP_ROUTE: begin
				sh_route_dest[idx] = ip;
				sh_route_gw[idx] = gw;
				sh_route_valid[idx] = 1'b1;
			end
			OP_ARP: begin
				sh_arp_ip[idx] = ip;
				sh_arp_mac[idx] = mac;
				sh_arp_valid[idx] = 1'b1;
			end
			default: begin
				pending_resolutions.push_back(resolve_header(mac, et, ip, len));
			end
		endcase
	endtask

	// Stop sending and wait until every header has been resolved.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_resolutions.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_subnet(logic [1:0] index, logic [23:0] value);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_PORT1:   sh_port1 = value;
			CFG_PORT2_A: sh_port2_a = value;
			CFG_PORT2_B: sh_port2_b = value;
			default: ;
		endcase
	endtask

	task automatic send_frame(logic [47:0] mac, logic [15:0] et, logic [31:0] ip,
			logic [11:0] len);
		send_request(OP_FRAME, 5'($urandom), mac, et, ip, 32'($urandom), len);
	endtask

	// Walk every status from an empty table up to forwarding on each port.
	task automatic test_lookup_chain();
		logic [47:0] mac;
		mac = 48'h0200_0000_0001;
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd41);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd0);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd42);
		send_request(OP_LOCAL, 5'd3, mac, '0, '0, '0, '0);
		send_request(OP_LOCAL, 5'd15, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
		send_frame(mac, 16'h86DD, 32'hC0A8_0005, 12'd64);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd4095);
		send_request(OP_ROUTE, 5'd0, '0, '0, 32'hC0A8_0005, 32'h0A00_0001, '0);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd64);
		send_request(OP_ARP, 5'd31, 48'h00AA_BBCC_DDEE, '0, 32'h0A00_0001, '0, '0);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd2048);
		send_request(OP_ROUTE, 5'd31, '0, '0, 32'hC0A8_0107, 32'h0A00_0001, '0);
		send_request(OP_ROUTE, 5'd7, '0, '0, 32'hC0A8_0207, 32'h0A00_0001, '0);
		send_request(OP_ROUTE, 5'd8, '0, '0, 32'hFFFF_FFFF, 32'h0A00_0001, '0);
		send_frame(48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4, 32'hC0A8_0107, 12'd64);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0207, 12'd64);
		send_frame(mac, ETHERTYPE_IPV4, 32'hFFFF_FFFF, 12'd64);
		// Writes past the local table are dropped.
		send_request(OP_LOCAL, 5'd16, 48'h1111_2222_3333, '0, '0, '0, '0);
		send_frame(48'h1111_2222_3333, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd64);
		// A lower duplicate slot wins; a rewrite replaces the entry.
		send_request(OP_ARP, 5'd2, 48'h0012_3456_789A, '0, 32'h0A00_0001, '0, '0);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd64);
		send_request(OP_ARP, 5'd2, 48'h0, '0, 32'h0A00_0002, '0, '0);
		send_frame(mac, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd64);
	endtask

	// Extreme subnet values, equal subnets and the index past the list.
	task automatic test_subnet_registers();
		write_subnet(CFG_PORT1, 24'h000000);
		write_subnet(CFG_PORT2_A, 24'hFFFFFF);
		write_subnet(CFG_PORT2_B, 24'hC0A800);
		write_subnet(2'd3, 24'h0A0000);
		send_request(OP_ROUTE, 5'd9, '0, '0, 32'h0000_0001, 32'h0A00_0001, '0);
		send_frame(48'h0200_0000_0001, ETHERTYPE_IPV4, 32'h0000_0001, 12'd64);
		send_frame(48'h0200_0000_0001, ETHERTYPE_IPV4, 32'hFFFF_FFFF, 12'd64);
		send_frame(48'h0200_0000_0001, ETHERTYPE_IPV4, 32'hC0A8_0005, 12'd64);
		write_subnet(CFG_PORT2_A, 24'h000000);
		send_frame(48'h0200_0000_0001, ETHERTYPE_IPV4, 32'h0000_0001, 12'd64);
	endtask

	task automatic refresh_pools();
		for (int k = 0; k < 8; k++) begin
			logic [23:0] net;
			case ($urandom_range(0, 3))
				0: net = sh_port1;
				1: net = sh_port2_a;
				2: net = sh_port2_b;
				default: net = 24'($urandom);
			endcase
			mac_pool[k] = {16'($urandom), 32'($urandom)};
			ip_pool[k] = {net, 8'($urandom)};
		end
	endtask

	// Random table writes and headers built from the address pools.
	task automatic test_random_traffic(int count, bit hold_off);
		for (int n = 0; n < count; n++) begin
			int pick;
			logic [11:0] len;
			pick = $urandom_range(0, 99);
			if (n % 64 == 0) refresh_pools();
			if (hold_off && n == count / 2) drain_pipeline();
			if (pick < 12) begin
				send_request(OP_LOCAL, 5'($urandom), mac_pool[$urandom_range(0, 7)],
					16'($urandom), 32'($urandom), 32'($urandom), 12'($urandom));
			end else if (pick < 24) begin
				send_request(OP_ROUTE, 5'($urandom), {16'($urandom), 32'($urandom)},
					16'($urandom), ip_pool[$urandom_range(0, 7)],
					ip_pool[$urandom_range(0, 7)], 12'($urandom));
			end else if (pick < 36) begin
				send_request(OP_ARP, 5'($urandom), {16'($urandom), 32'($urandom)},
					16'($urandom), ip_pool[$urandom_range(0, 7)], 32'($urandom),
					12'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0: len = 12'($urandom_range(0, 41));
					1: len = 12'($urandom);
					default: len = 12'($urandom_range(42, 1518));
				endcase
				send_frame(($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
						: mac_pool[$urandom_range(0, 7)],
					($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4,
					($urandom_range(0, 9) == 0) ? 32'($urandom)
						: ip_pool[$urandom_range(0, 7)],
					len);
			end
		end
	endtask

	// Check each result against the oldest pending resolution.
	initial begin
		resolution_t exp_res;
		resolution_t got;
		int          stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = {m_tuser, m_tdata[1:0], m_tdata[49:2], m_tdata[97:50],
				m_tdata[102:98], m_tdata[107:103]};
			if (pending_resolutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d tdata %h", m_tuser, m_tdata);
			end else begin
				exp_res = pending_resolutions.pop_front();
				if (got !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected status %0d port %0d dst %h src %h ",
							"route %0d arp %0d, got status %0d port %0d dst %h src %h ",
							"route %0d arp %0d"},
							exp_res.status, exp_res.port, exp_res.dst_mac,
							exp_res.src_mac, exp_res.route_slot, exp_res.arp_slot,
							got.status, got.port, got.dst_mac, got.src_mac,
							got.route_slot, got.arp_slot);
				end
			end
		end
	end

	// End the run when nothing is accepted for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_FRAME;
		cfg_valid = 1'b0;
		cfg_index = CFG_PORT1;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		no_idle = 0;
		sh_port1 = PORT1_RESET;
		sh_port2_a = PORT2_A_RESET;
		sh_port2_b = PORT2_B_RESET;
		for (int k = 0; k < LOCAL_ENTRIES; k++) begin
			sh_local_mac[k] = '0;
			sh_local_valid[k] = 1'b0;
		end
		for (int k = 0; k < ROUTE_ENTRIES; k++) begin
			sh_route_dest[k] = '0;
			sh_route_gw[k] = '0;
			sh_route_valid[k] = 1'b0;
			sh_arp_ip[k] = '0;
			sh_arp_mac[k] = '0;
			sh_arp_valid[k] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lookup_chain();
		test_subnet_registers();

		// Phase with reset-like subnets, then extremes, then random values.
		write_subnet(CFG_PORT1, PORT1_RESET);
		write_subnet(CFG_PORT2_A, PORT2_A_RESET);
		write_subnet(CFG_PORT2_B, PORT2_B_RESET);
		test_random_traffic(260, 1'b1);
		write_subnet(CFG_PORT1, 24'hFFFFFF);
		write_subnet(CFG_PORT2_A, 24'h000000);
		write_subnet(CFG_PORT2_B, 24'hFFFFFF);
		no_idle = 1;
		test_random_traffic(260, 1'b0);
		no_idle = 0;
		write_subnet(CFG_PORT1, 24'($urandom));
		write_subnet(CFG_PORT2_A, 24'($urandom));
		write_subnet(CFG_PORT2_B, 24'($urandom));
		test_random_traffic(260, 1'b0);
		write_subnet(CFG_PORT2_B, sh_port1);
		test_random_traffic(260, 1'b0);

		drain_pipeline();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_resolutions.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: ipv4_forwarding_lookup.f
rtl/ifl_pkg.sv
rtl/ifl_ctrl.sv
rtl/ifl_datapath.sv
rtl/ipv4_forwarding_lookup.sv
tb/sv/testbench.sv
